// ===== rtl/slbm_pkg.sv =====
// shared types and constants for the serial loaded bank mapper
`timescale 1ns / 1ps

package slbm_pkg;

    // bus access commands
    localparam logic [1:0] CMD_CPU_RD = 2'd0;
    localparam logic [1:0] CMD_CPU_WR = 2'd1;
    localparam logic [1:0] CMD_PPU_RD = 2'd2;
    localparam logic [1:0] CMD_PPU_WR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
    localparam logic [1:0] CFG_INIT_MIR  = 2'd2;

    // mirroring codes
    localparam logic [2:0] MIR_VERTICAL    = 3'd2;
    localparam logic [2:0] MIR_FOUR_SCREEN = 3'd4;

    // serial loader
    localparam int unsigned SERIAL_BITS = 5;
    localparam int unsigned CNT_W       = 3;

    // reset values of configuration
    localparam logic [5:0] PRG_COUNT_RST = 6'd2;
    localparam logic [5:0] CHR_COUNT_RST = 6'd0;

    // address boundaries
    localparam logic [15:0] CPU_ROM_BASE = 16'h8000;
    localparam logic [15:0] PPU_CHR_TOP  = 16'h1FFF;

    // loaded value targets, selected by cpu address bits 14:13
    localparam logic [1:0] TGT_CONTROL  = 2'd0;
    localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
    localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
    localparam logic [1:0] TGT_PRG      = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_bus_req;

    typedef struct packed {
        logic        mapped_hit;
        logic [18:0] rom_offset;
        logic [2:0]  mirroring_mode;
    } t_map_rsp;

    // banking state seen by the address mapper
    typedef struct packed {
        logic [4:0] prg_bank;
        logic [4:0] chr_bank_low;
        logic [4:0] chr_bank_high;
        logic       low_half_switches;
        logic       prg_whole_32k;
        logic       chr_whole_8k;
        logic [5:0] prg_bank_count;
        logic [5:0] chr_bank_count;
    } t_bank_state;

endpackage

// ===== rtl/serial_loaded_bank_mapper_top.sv =====
// top level of the serial loaded bank mapper
//
// Cartridge bank mapper with a five-bit serial loading port. Each input
// transaction on i_in is one bus access (cpu read/write, ppu read/write);
// each produces exactly one output transaction on o_out carrying the hit
// flag, the mapped rom offset and the mirroring mode after that access.
// Channels use valid/stall: a transaction moves when valid is high and
// stall is low. Configuration registers (prg bank count, chr bank count,
// initial mirroring) are written through i_cfg_valid/o_cfg_ready, index
// and data; ready is always high and writes are meant for idle periods.
// The path has two registers: the input register, then the mapper and
// loader update into the result register. Throughput is one access per
// cycle while the receiver does not stall; the serial loader state is
// updated in the same cycle as the access reaches the result register,
// so back-to-back writes chain without a bubble.
// When the receiver stalls, the result register holds and the input
// register fills; then o_in_stall rises until the result is taken.
// Synchronous active-low reset empties both registers and restores the
// bank and control state to power-on values.
`timescale 1ns / 1ps

module serial_loaded_bank_mapper_top
    import slbm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_bus_req   i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_map_rsp   o_out,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data
);

    logic        r_in_valid;
    t_bus_req    r_in;
    logic        r_out_valid;
    t_map_rsp    r_out;

    logic        advance;
    logic        step;
    t_bank_state bank_state;
    logic [2:0]  next_mirroring;
    logic        map_hit;
    logic [18:0] map_offset;

    // pipeline control
    assign advance     = !r_out_valid || !i_out_stall;
    assign step        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_cfg_ready = 1'b1;

    slbm_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_step           (step),
        .i_req            (r_in),
        .o_state          (bank_state),
        .o_next_mirroring (next_mirroring)
    );

    slbm_map u_map (
        .i_req    (r_in),
        .i_state  (bank_state),
        .o_hit    (map_hit),
        .o_offset (map_offset)
    );

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.mapped_hit     <= map_hit;
            r_out.rom_offset     <= map_offset;
            r_out.mirroring_mode <= next_mirroring;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/slbm_ctrl.sv =====
// serial loader, bank registers, control state and configuration registers
`timescale 1ns / 1ps

module slbm_ctrl
    import slbm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data,
    input  logic        i_step,
    input  t_bus_req    i_req,
    output t_bank_state o_state,
    output logic [2:0]  o_next_mirroring
);

    logic [3:0]       r_shift_bits, n_shift_bits;
    logic [CNT_W-1:0] r_shift_count, n_shift_count;
    logic [4:0]       r_prg_bank, n_prg_bank;
    logic [4:0]       r_chr_low, n_chr_low;
    logic [4:0]       r_chr_high, n_chr_high;
    logic             r_low_half, n_low_half;
    logic             r_prg_32k, n_prg_32k;
    logic             r_chr_8k, n_chr_8k;
    logic [2:0]       r_mirroring, n_mirroring;
    logic [5:0]       r_prg_count, n_prg_count;
    logic [5:0]       r_chr_count, n_chr_count;
    logic [2:0]       r_init_mir, n_init_mir;

    logic             rom_write;
    logic [4:0]       loaded;
    logic [2:0]       cfg_mir;

    assign rom_write = i_step && (i_req.command == CMD_CPU_WR)
                       && (i_req.bus_address >= CPU_ROM_BASE);
    assign loaded  = {i_req.write_data[0], r_shift_bits};
    assign cfg_mir = (i_cfg_data[2:0] > MIR_FOUR_SCREEN) ? MIR_FOUR_SCREEN
                                                         : i_cfg_data[2:0];

    // next state: configuration first, then the serial write path
    always_comb begin
        n_shift_bits  = r_shift_bits;
        n_shift_count = r_shift_count;
        n_prg_bank    = r_prg_bank;
        n_chr_low     = r_chr_low;
        n_chr_high    = r_chr_high;
        n_low_half    = r_low_half;
        n_prg_32k     = r_prg_32k;
        n_chr_8k      = r_chr_8k;
        n_mirroring   = r_mirroring;
        n_prg_count   = r_prg_count;
        n_chr_count   = r_chr_count;
        n_init_mir    = r_init_mir;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PRG_COUNT: n_prg_count = i_cfg_data;
                CFG_CHR_COUNT: n_chr_count = i_cfg_data;
                CFG_INIT_MIR: begin
                    n_init_mir  = cfg_mir;
                    n_mirroring = cfg_mir;
                end
                default: ;
            endcase
        end else if (rom_write) begin
            if (i_req.write_data[7]) begin
                // reset write
                n_shift_bits  = '0;
                n_shift_count = '0;
                n_low_half    = 1'b1;
                n_prg_32k     = 1'b0;
                n_chr_8k      = 1'b0;
                n_mirroring   = r_init_mir;
            end else if (r_shift_count == CNT_W'(SERIAL_BITS - 1)) begin
                // fifth bit: store the assembled value
                n_shift_bits  = '0;
                n_shift_count = '0;
                unique case (i_req.bus_address[14:13])
                    TGT_CONTROL: begin
                        n_prg_32k = (loaded[3:2] <= 2'd1);
                        if (loaded[3:2] == 2'd2) begin
                            n_low_half = 1'b0;
                        end else if (loaded[3:2] == 2'd3) begin
                            n_low_half = 1'b1;
                        end
                        n_chr_8k = ~loaded[4];
                        if (r_mirroring != MIR_FOUR_SCREEN) begin
                            n_mirroring = {1'b0, loaded[1:0]};
                        end
                    end
                    TGT_CHR_LOW:  n_chr_low  = loaded;
                    TGT_CHR_HIGH: n_chr_high = loaded;
                    TGT_PRG:      n_prg_bank = loaded;
                    default: ;
                endcase
            end else begin
                // shift in one bit, lsb first
                n_shift_bits  = r_shift_bits
                                | (4'(i_req.write_data[0]) << r_shift_count[1:0]);
                n_shift_count = r_shift_count + CNT_W'(1);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_bits  <= '0;
            r_shift_count <= '0;
            r_prg_bank    <= '0;
            r_chr_low     <= '0;
            r_chr_high    <= '0;
            r_low_half    <= 1'b1;
            r_prg_32k     <= 1'b0;
            r_chr_8k      <= 1'b0;
            r_mirroring   <= MIR_VERTICAL;
            r_prg_count   <= PRG_COUNT_RST;
            r_chr_count   <= CHR_COUNT_RST;
            r_init_mir    <= MIR_VERTICAL;
        end else begin
            r_shift_bits  <= n_shift_bits;
            r_shift_count <= n_shift_count;
            r_prg_bank    <= n_prg_bank;
            r_chr_low     <= n_chr_low;
            r_chr_high    <= n_chr_high;
            r_low_half    <= n_low_half;
            r_prg_32k     <= n_prg_32k;
            r_chr_8k      <= n_chr_8k;
            r_mirroring   <= n_mirroring;
            r_prg_count   <= n_prg_count;
            r_chr_count   <= n_chr_count;
            r_init_mir    <= n_init_mir;
        end
    end

    assign o_state.prg_bank          = r_prg_bank;
    assign o_state.chr_bank_low      = r_chr_low;
    assign o_state.chr_bank_high     = r_chr_high;
    assign o_state.low_half_switches = r_low_half;
    assign o_state.prg_whole_32k     = r_prg_32k;
    assign o_state.chr_whole_8k      = r_chr_8k;
    assign o_state.prg_bank_count    = r_prg_count;
    assign o_state.chr_bank_count    = r_chr_count;
    assign o_next_mirroring          = n_mirroring;

endmodule

// ===== rtl/slbm_map.sv =====
// address mapper: turns a bus access into a hit flag and rom offset
`timescale 1ns / 1ps

module slbm_map
    import slbm_pkg::*;
(
    input  t_bus_req    i_req,
    input  t_bank_state i_state,
    output logic        o_hit,
    output logic [18:0] o_offset
);

    logic [15:0] addr;
    logic [3:0]  prg4;
    logic [4:0]  last_bank;
    logic [4:0]  prg_sel;
    logic [18:0] prg_off;
    logic [18:0] chr_off;
    logic        cpu_rom;
    logic        ppu_chr;
    logic        chr_ram;

    assign addr      = i_req.bus_address;
    assign prg4      = i_state.prg_bank[3:0];
    assign last_bank = 5'(i_state.prg_bank_count - 6'd1);
    assign cpu_rom   = (addr >= CPU_ROM_BASE);
    assign ppu_chr   = (addr <= PPU_CHR_TOP);
    assign chr_ram   = (i_state.chr_bank_count == 6'd0);

    // prg banking: 32k whole, or 16k with one half fixed
    always_comb begin
        if (!addr[14]) begin
            prg_sel = i_state.low_half_switches ? {1'b0, prg4} : 5'd0;
        end else begin
            prg_sel = i_state.low_half_switches ? last_bank : {1'b0, prg4};
        end
        if (i_state.prg_whole_32k) begin
            prg_off = {1'b0, prg4[3:1], addr[14:0]};
        end else begin
            prg_off = {prg_sel, addr[13:0]};
        end
    end

    // chr banking: ram pass-through, 8k whole, or two 4k halves
    always_comb begin
        if (chr_ram) begin
            chr_off = {3'd0, addr};
        end else if (i_state.chr_whole_8k) begin
            chr_off = {2'd0, i_state.chr_bank_low[4:1], addr[12:0]};
        end else if (!addr[12]) begin
            chr_off = {2'd0, i_state.chr_bank_low, addr[11:0]};
        end else begin
            chr_off = {2'd0, i_state.chr_bank_high, addr[11:0]};
        end
    end

    // command decode
    always_comb begin
        o_hit    = 1'b0;
        o_offset = '0;
        unique case (i_req.command)
            CMD_CPU_RD: begin
                if (cpu_rom) begin
                    o_hit    = 1'b1;
                    o_offset = prg_off;
                end
            end
            CMD_CPU_WR: ;
            CMD_PPU_RD: begin
                if (ppu_chr) begin
                    o_hit    = 1'b1;
                    o_offset = chr_off;
                end
            end
            CMD_PPU_WR: begin
                if (ppu_chr && chr_ram) begin
                    o_hit    = 1'b1;
                    o_offset = {3'd0, addr};
                end
            end
            default: ;
        endcase
    end

endmodule

// ===== rtl/slbm_checker.sv =====
// port-level checker for the serial loaded bank mapper, bound to the top level
`timescale 1ns / 1ps

module slbm_checker
    import slbm_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_stall,
    input logic     o_out_valid,
    input logic     i_out_stall,
    input t_map_rsp o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed");

    // an unclaimed access reports a zero offset
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.mapped_hit |-> o_out.rom_offset == 19'd0)
        else $error("miss with nonzero offset");

    // mirroring stays within the defined codes
    a_mir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.mirroring_mode <= MIR_FOUR_SCREEN)
        else $error("mirroring code out of range");

    // nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // with the result register empty the block never stalls the sender
    a_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty result register");

endmodule

bind serial_loaded_bank_mapper_top slbm_checker u_slbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
